/* hw/rtl/sorted_bounded_entry_buffer_assert.svh */
// Assertion macros for the sorted bounded entry buffer checkers.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef SORTED_BOUNDED_ENTRY_BUFFER_ASSERT_SVH
`define SORTED_BOUNDED_ENTRY_BUFFER_ASSERT_SVH

// same-cycle implication
`define SBEB_ASSERT_IMP(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBEB_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sbeb_pkg.sv */
// Shared types, field widths and codes of the sorted bounded entry buffer.
// No dependencies; used by every other file of the block but the assertion header.
package sbeb_pkg;

	localparam int DEPTH_DEF = 64;

	localparam int KIND_W = 2;
	localparam int ID_W   = 32;
	localparam int PAY_W  = 64;
	localparam int RIDX_W = 6;
	localparam int CONV_W = 9;
	localparam int STAT_W = 3;
	localparam int POS_W  = 6;
	localparam int CNT_W  = 7;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
	// bit 1 of kind selects a read, so the unused code reads too
	localparam int KIND_READ_BIT = 1;

	localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STAT_W-1:0] ST_REPLACED = 3'd1;
	localparam logic [STAT_W-1:0] ST_REJECTED = 3'd2;
	localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd3;
	localparam logic [STAT_W-1:0] ST_READ_OK  = 3'd4;
	localparam logic [STAT_W-1:0] ST_READ_OOR = 3'd5;

	localparam logic signed [CONV_W-1:0] CONV_NONE = -9'sd1;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_SHIFT_UP,
		MODE_SHIFT_DN,
		MODE_REPLACE
	} cell_mode_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                    cmp_en;
		cell_mode_t              mode;
		logic signed [ID_W-1:0]  id;
		logic [PAY_W-1:0]        payload;
	} cell_cmd_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cell_flags_t;

endpackage

/* hw/rtl/sbeb_in_if.sv */
// Request channel of the sorted bounded entry buffer: valid/ready plus one input word.
// Depends on sbeb_pkg for field widths.
interface sbeb_in_if
	import sbeb_pkg::*;
	;
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [ID_W-1:0]   entry_id;
	logic [PAY_W-1:0]         entry_payload;
	logic [RIDX_W-1:0]        read_index;
	logic signed [CONV_W-1:0] conversation_in;

	modport source (
		output valid, kind, entry_id, entry_payload, read_index, conversation_in,
		input  ready
	);
	modport sink (
		input  valid, kind, entry_id, entry_payload, read_index, conversation_in,
		output ready
	);
endinterface

/* hw/rtl/sbeb_out_if.sv */
// Result channel of the sorted bounded entry buffer: valid/ready plus one result word.
// Depends on sbeb_pkg for field widths.
interface sbeb_out_if
	import sbeb_pkg::*;
	;
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic [POS_W-1:0]         position;
	logic                     evicted;
	logic [CNT_W-1:0]         entry_count;
	logic signed [ID_W-1:0]   oldest_id;
	logic signed [ID_W-1:0]   read_id;
	logic [PAY_W-1:0]         read_payload;
	logic signed [CONV_W-1:0] conversation;

	modport source (
		output valid, status, position, evicted, entry_count, oldest_id, read_id,
			read_payload, conversation,
		input  ready
	);
	modport sink (
		input  valid, status, position, evicted, entry_count, oldest_id, read_id,
			read_payload, conversation,
		output ready
	);
endinterface

/* hw/rtl/sorted_bounded_entry_buffer.sv */
// Sorted bounded entry buffer: up to DEPTH entries (signed 32-bit id, 64-bit payload)
// kept in ascending id order in a chain of cells, index 0 holding the oldest. Every
// request word gives one result word. A request is taken only while the controller is
// idle; its result goes through compare, update and collect, and load into the output
// register, and the controller is idle again once it loads, so a new request is not
// taken before the last result is loaded. All cells compare against the new id together
// and shift toward their neighbors in the next cycle, and a read is gathered through a
// two-level registered OR tree. A finished result may wait in the output register while
// the next request is taken and worked on. Entry storage needs no clearing after reset.
// Depends on sbeb_pkg, sbeb_in_if, sbeb_out_if, sbeb_cell and sbeb_ctrl.
module sorted_bounded_entry_buffer
	import sbeb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sbeb_in_if.sink     req,
	sbeb_out_if.source  rsp
);

	cell_cmd_t              cmd;
	logic [DEPTH-1:0]       occ;
	logic [DEPTH-1:0]       rd_sel;
	cell_flags_t            flags [DEPTH];
	logic signed [ID_W-1:0] cell_id [DEPTH];
	logic [PAY_W-1:0]       cell_pay [DEPTH];
	logic [ID_W-1:0]        rd_id [DEPTH];
	logic [PAY_W-1:0]       rd_payload [DEPTH];

	sbeb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.occ       (occ),
		.rd_sel    (rd_sel),
		.flags     (flags),
		.head_id   (cell_id[0]),
		.rd_id     (rd_id),
		.rd_payload(rd_payload)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                   lt_prev, lt_next;
		logic signed [ID_W-1:0] prev_id, next_id;
		logic [PAY_W-1:0]       prev_pay, next_pay;

		if (i == 0) begin : g_head
			assign lt_prev  = 1'b1;
			assign prev_id  = '0;
			assign prev_pay = '0;
		end else begin : g_mid_lo
			assign lt_prev  = flags[i-1].lt;
			assign prev_id  = cell_id[i-1];
			assign prev_pay = cell_pay[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign lt_next  = 1'b0;
			assign next_id  = '0;
			assign next_pay = '0;
		end else begin : g_mid_hi
			assign lt_next  = flags[i+1].lt;
			assign next_id  = cell_id[i+1];
			assign next_pay = cell_pay[i+1];
		end

		sbeb_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.occ         (occ[i]),
			.rd_sel      (rd_sel[i]),
			.lt_prev     (lt_prev),
			.lt_next     (lt_next),
			.prev_id     (prev_id),
			.prev_payload(prev_pay),
			.next_id     (next_id),
			.next_payload(next_pay),
			.flags       (flags[i]),
			.id          (cell_id[i]),
			.payload     (cell_pay[i]),
			.rd_id       (rd_id[i]),
			.rd_payload  (rd_payload[i])
		);
	end

endmodule

/* hw/rtl/sbeb_cell.sv */
// One slot of the sorted entry chain: id, payload, compare flags and neighbor shifting.
// Depends on sbeb_pkg for cell_cmd_t and cell_flags_t.
module sbeb_cell
	import sbeb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_cmd_t              cmd,
	input  logic                   occ,
	input  logic                   rd_sel,
	input  logic                   lt_prev,
	input  logic                   lt_next,
	input  logic signed [ID_W-1:0] prev_id,
	input  logic [PAY_W-1:0]       prev_payload,
	input  logic signed [ID_W-1:0] next_id,
	input  logic [PAY_W-1:0]       next_payload,
	output cell_flags_t            flags,
	output logic signed [ID_W-1:0] id,
	output logic [PAY_W-1:0]       payload,
	output logic [ID_W-1:0]        rd_id,
	output logic [PAY_W-1:0]       rd_payload
);

	cell_flags_t            flags_q;
	logic                   sel_q;
	logic signed [ID_W-1:0] id_q;
	logic [PAY_W-1:0]       payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			sel_q   <= 1'b0;
		end else if (cmd.cmp_en) begin
			flags_q.lt <= occ && ($signed(id_q) < $signed(cmd.id));
			flags_q.eq <= occ && (id_q == cmd.id);
			sel_q      <= rd_sel;
		end
	end

	// flags are from the compare cycle, so neighbors see a consistent picture
	always_ff @(posedge clk) begin
		case (cmd.mode)
			MODE_SHIFT_UP: begin
				if (!flags_q.lt) begin
					if (lt_prev) begin
						id_q      <= cmd.id;
						payload_q <= cmd.payload;
					end else begin
						id_q      <= prev_id;
						payload_q <= prev_payload;
					end
				end
			end
			MODE_SHIFT_DN: begin
				if (lt_next) begin
					id_q      <= next_id;
					payload_q <= next_payload;
				end else if (flags_q.lt) begin
					id_q      <= cmd.id;
					payload_q <= cmd.payload;
				end
			end
			MODE_REPLACE: begin
				if (flags_q.eq) begin
					payload_q <= cmd.payload;
				end
			end
			default: begin
			end
		endcase
	end

	assign flags      = flags_q;
	assign id         = id_q;
	assign payload    = payload_q;
	assign rd_id      = sel_q ? id_q : '0;
	assign rd_payload = sel_q ? payload_q : '0;

endmodule

/* hw/rtl/sbeb_ctrl.sv */
// Sequencer of the entry buffer: input capture, cell commands, position encode,
// read collection and the result register. Depends on sbeb_pkg and both channel interfaces.
module sbeb_ctrl
	import sbeb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	sbeb_in_if.sink                req,
	sbeb_out_if.source             rsp,
	output cell_cmd_t              cmd,
	output logic [DEPTH-1:0]       occ,
	output logic [DEPTH-1:0]       rd_sel,
	input  cell_flags_t            flags [DEPTH],
	input  logic signed [ID_W-1:0] head_id,
	input  logic [ID_W-1:0]        rd_id [DEPTH],
	input  logic [PAY_W-1:0]       rd_payload [DEPTH]
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int GS = 8;
	localparam int NG = (DEPTH + GS - 1) / GS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;

	logic [KIND_W-1:0]        kind_s1;
	logic signed [ID_W-1:0]   id_s1;
	logic [PAY_W-1:0]         pay_s1;
	logic [RIDX_W-1:0]        ridx_s1;
	logic signed [CONV_W-1:0] conv_s1;

	logic [CW-1:0]            count_q;
	logic signed [CONV_W-1:0] conv_q;

	logic [STAT_W-1:0] status_s2;
	logic [POS_W-1:0]  pos_s2;
	logic              ev_s2;
	logic              rd_ok_s2;
	logic [ID_W-1:0]   grp_id_s2 [NG];
	logic [PAY_W-1:0]  grp_pay_s2 [NG];

	logic                     rsp_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic [POS_W-1:0]         pos_q;
	logic                     ev_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [ID_W-1:0]   oldest_q;
	logic signed [ID_W-1:0]   rid_q;
	logic [PAY_W-1:0]         rpay_q;
	logic signed [CONV_W-1:0] conv_out_q;

	logic [DEPTH-1:0] lt_v, eq_v, ins_oh, dn_oh;
	logic [IW-1:0]    eq_pos, ins_pos, dn_pos;
	logic             found, full, is_ins, is_clr, is_rd, rd_ok;
	cell_mode_t       mode;
	logic [STAT_W-1:0] status_d;
	logic [POS_W-1:0]  pos_d;
	logic              ev_d;
	logic [ID_W-1:0]   grp_id_d [NG];
	logic [PAY_W-1:0]  grp_pay_d [NG];
	logic [ID_W-1:0]   rid_fin;
	logic [PAY_W-1:0]  rpay_fin;
	logic              load_out;

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i]    = int'(count_q) > i;
			rd_sel[i] = int'(ridx_s1) == i;
		end
	end

	assign is_ins = (kind_s1 == KIND_INSERT);
	assign is_clr = (kind_s1 == KIND_CLEAR);
	assign is_rd  = kind_s1[KIND_READ_BIT];
	assign full   = (count_q == CW'(DEPTH));
	assign rd_ok  = int'(ridx_s1) < int'(count_q);

	// ins_oh marks the slot a non-full insert lands in, dn_oh the slot after an eviction
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			lt_v[i] = flags[i].lt;
			eq_v[i] = flags[i].eq;
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (i == 0) begin
				ins_oh[i] = !lt_v[i];
			end else begin
				ins_oh[i] = !lt_v[i] && lt_v[i-1];
			end
			if (i == DEPTH - 1) begin
				dn_oh[i] = lt_v[i];
			end else begin
				dn_oh[i] = lt_v[i] && !lt_v[i+1];
			end
		end
		eq_pos  = '0;
		ins_pos = '0;
		dn_pos  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (eq_v[i])   eq_pos  = eq_pos  | IW'(i);
			if (ins_oh[i]) ins_pos = ins_pos | IW'(i);
			if (dn_oh[i])  dn_pos  = dn_pos  | IW'(i);
		end
	end

	assign found = |eq_v;

	always_comb begin
		mode     = MODE_HOLD;
		status_d = ST_INSERTED;
		pos_d    = '0;
		ev_d     = 1'b0;
		if (is_rd) begin
			status_d = rd_ok ? ST_READ_OK : ST_READ_OOR;
			pos_d    = POS_W'(ridx_s1);
		end else if (is_clr) begin
			status_d = ST_CLEARED;
		end else if (found) begin
			mode     = MODE_REPLACE;
			status_d = ST_REPLACED;
			pos_d    = POS_W'(eq_pos);
		end else if (!full) begin
			mode     = MODE_SHIFT_UP;
			pos_d    = POS_W'(ins_pos);
		end else if (lt_v[0]) begin
			mode     = MODE_SHIFT_DN;
			pos_d    = POS_W'(dn_pos);
			ev_d     = 1'b1;
		end else begin
			status_d = ST_REJECTED;
		end
		if (state_q != S_UPD || !is_ins) begin
			mode = MODE_HOLD;
		end
	end

	always_comb begin
		cmd.cmp_en  = (state_q == S_CMP);
		cmd.mode    = mode;
		cmd.id      = id_s1;
		cmd.payload = pay_s1;
	end

	// first level of the read collection tree; only the selected cell is nonzero
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_id_d[g]  = '0;
			grp_pay_d[g] = '0;
			for (int j = 0; j < GS; j++) begin
				if (g * GS + j < DEPTH) begin
					grp_id_d[g]  = grp_id_d[g]  | rd_id[g*GS+j];
					grp_pay_d[g] = grp_pay_d[g] | rd_payload[g*GS+j];
				end
			end
		end
	end

	always_comb begin
		rid_fin  = '0;
		rpay_fin = '0;
		for (int g = 0; g < NG; g++) begin
			rid_fin  = rid_fin  | grp_id_s2[g];
			rpay_fin = rpay_fin | grp_pay_s2[g];
		end
	end

	assign load_out = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			conv_q      <= CONV_NONE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (is_clr) begin
						count_q <= '0;
						conv_q  <= conv_s1;
					end else if (is_ins && !found && !full) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1 <= req.kind;
			id_s1   <= req.entry_id;
			pay_s1  <= req.entry_payload;
			ridx_s1 <= req.read_index;
			conv_s1 <= req.conversation_in;
		end
		if (state_q == S_UPD) begin
			status_s2  <= status_d;
			pos_s2     <= pos_d;
			ev_s2      <= ev_d;
			rd_ok_s2   <= is_rd && rd_ok;
			grp_id_s2  <= grp_id_d;
			grp_pay_s2 <= grp_pay_d;
		end
		if (load_out) begin
			status_q   <= status_s2;
			pos_q      <= pos_s2;
			ev_q       <= ev_s2;
			cnt_q      <= CNT_W'(count_q);
			oldest_q   <= (count_q != '0) ? head_id : '0;
			rid_q      <= rd_ok_s2 ? rid_fin : '0;
			rpay_q     <= rd_ok_s2 ? rpay_fin : '0;
			conv_out_q <= conv_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.position     = pos_q;
	assign rsp.evicted      = ev_q;
	assign rsp.entry_count  = cnt_q;
	assign rsp.oldest_id    = oldest_q;
	assign rsp.read_id      = rid_q;
	assign rsp.read_payload = rpay_q;
	assign rsp.conversation = conv_out_q;

endmodule

/* hw/rtl/sbeb_checker.sv */
// Port-level checks on the result channel of the sorted bounded entry buffer,
// bound to the top level. Depends on sbeb_pkg and sorted_bounded_entry_buffer_assert.svh.
`include "sorted_bounded_entry_buffer_assert.svh"

module sbeb_checker
	import sbeb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [STAT_W-1:0]      status,
	input logic                   evicted,
	input logic [CNT_W-1:0]       entry_count,
	input logic signed [ID_W-1:0] oldest_id,
	input logic signed [ID_W-1:0] read_id,
	input logic [PAY_W-1:0]       read_payload
);

	`SBEB_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(entry_count), "result word changed while stalled")
	`SBEB_ASSERT_IMP(a_read_zero, rsp_valid && status != ST_READ_OK, read_id == '0 && read_payload == '0, "read fields nonzero without a good read")
	`SBEB_ASSERT_IMP(a_empty_oldest, rsp_valid && (entry_count == '0 || status == ST_CLEARED), entry_count == '0 && oldest_id == '0, "empty buffer reports an oldest id")
	`SBEB_ASSERT_IMP(a_evict_full, rsp_valid && evicted, status == ST_INSERTED && entry_count == CNT_W'(DEPTH), "eviction without a full buffer")

endmodule

bind sorted_bounded_entry_buffer sbeb_checker #(
	.DEPTH(DEPTH)
) u_sbeb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.evicted     (rsp.evicted),
	.entry_count (rsp.entry_count),
	.oldest_id   (rsp.oldest_id),
	.read_id     (rsp.read_id),
	.read_payload(rsp.read_payload)
);

/* tb/sorted_bounded_entry_buffer_test.sv */
// Testbench for sorted_bounded_entry_buffer: a queue-fed request driver, a result monitor
// and a built-in buffer predictor; runs directed words, then random insert/read/clear runs.
// Depends on sbeb_pkg, sbeb_in_if, sbeb_out_if and the buffer RTL.
`timescale 1ns / 100ps

module sorted_bounded_entry_buffer_test;
	import sbeb_pkg::*;

	localparam int BUF_DEPTH = DEPTH_DEF;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam logic signed [ID_W-1:0] ID_MIN = 32'sh80000000;
	localparam logic signed [ID_W-1:0] ID_MAX = 32'sh7fffffff;
	localparam int RUN_WORDS    = 520;
	localparam int DRAIN_CYCLES = 16;

	typedef enum int {IDS_WIDE, IDS_WINDOW, IDS_RISING} id_pattern_t;

	typedef struct {
		logic [KIND_W-1:0]        kind;
		logic signed [ID_W-1:0]   id;
		logic [PAY_W-1:0]         payload;
		logic [RIDX_W-1:0]        idx;
		logic signed [CONV_W-1:0] conv;
	} buf_op_t;

	typedef struct {
		logic [STAT_W-1:0]        status;
		logic [POS_W-1:0]         position;
		logic                     evicted;
		logic [CNT_W-1:0]         count;
		logic signed [ID_W-1:0]   oldest;
		logic signed [ID_W-1:0]   rd_id;
		logic [PAY_W-1:0]         rd_pay;
		logic signed [CONV_W-1:0] conv;
	} buf_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sbeb_in_if  req ();
	sbeb_out_if rsp ();

	sorted_bounded_entry_buffer #(.DEPTH(BUF_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted buffer contents
	logic signed [ID_W-1:0]   held_ids [BUF_DEPTH];
	logic [PAY_W-1:0]         held_pays [BUF_DEPTH];
	int                       held_cnt;
	logic signed [CONV_W-1:0] conv_tag;

	buf_op_t  pending_ops [$];
	buf_rsp_t awaited_rsps [$];
	buf_op_t  next_op;
	buf_op_t  taken_op;
	buf_rsp_t want;
	logic     op_taken;
	int       send_gap_pct;
	int       recv_stall_pct;
	int       errors;

	function automatic buf_rsp_t buffer_apply(input buf_op_t op);
		buf_rsp_t r;
		int at;
		int i;
		bit hit;
		r = '{default: '0};
		if (op.kind == KIND_INSERT) begin
			hit = 1'b0;
			for (i = 0; i < held_cnt; i++) begin
				if (!hit && held_ids[i] == op.id) begin
					held_pays[i] = op.payload;
					r.status = ST_REPLACED;
					r.position = POS_W'(i);
					hit = 1'b1;
				end
			end
			if (!hit) begin
				at = held_cnt;
				while (at > 0 && held_ids[at-1] > op.id)
					at--;
				if (held_cnt >= BUF_DEPTH && at == 0) begin
					r.status = ST_REJECTED;
				end else begin
					if (held_cnt >= BUF_DEPTH) begin
						// full: drop the oldest entry first
						for (i = 0; i < BUF_DEPTH - 1; i++) begin
							held_ids[i] = held_ids[i+1];
							held_pays[i] = held_pays[i+1];
						end
						held_cnt = BUF_DEPTH - 1;
						at--;
						r.evicted = 1'b1;
					end
					for (i = held_cnt; i > at; i--) begin
						held_ids[i] = held_ids[i-1];
						held_pays[i] = held_pays[i-1];
					end
					held_ids[at] = op.id;
					held_pays[at] = op.payload;
					held_cnt++;
					r.status = ST_INSERTED;
					r.position = POS_W'(at);
				end
			end
		end else if (op.kind == KIND_CLEAR) begin
			held_cnt = 0;
			conv_tag = op.conv;
			r.status = ST_CLEARED;
		end else begin
			// both remaining kind codes read
			r.position = op.idx;
			if (op.idx < held_cnt) begin
				r.status = ST_READ_OK;
				r.rd_id = held_ids[op.idx];
				r.rd_pay = held_pays[op.idx];
			end else begin
				r.status = ST_READ_OOR;
			end
		end
		r.count = CNT_W'(held_cnt);
		r.oldest = (held_cnt > 0) ? held_ids[0] : '0;
		r.conv = conv_tag;
		return r;
	endfunction

	// all fields random, so unused fields toggle too
	function automatic buf_op_t random_op(input logic [KIND_W-1:0] kind);
		buf_op_t op;
		op.kind = kind;
		op.id = $urandom;
		op.payload = {$urandom, $urandom};
		op.idx = RIDX_W'($urandom_range(0, 63));
		op.conv = CONV_W'($urandom_range(0, 256) - 1);
		return op;
	endfunction

	task automatic queue_op(input logic [KIND_W-1:0] kind, input logic signed [ID_W-1:0] id,
			input logic [PAY_W-1:0] payload, input logic [RIDX_W-1:0] idx,
			input logic signed [CONV_W-1:0] conv);
		pending_ops.push_back('{kind, id, payload, idx, conv});
	endtask

	// one clear, then a run of inserts, reads and stray clears; returns words queued
	function automatic int queue_run(input bit force_window);
		id_pattern_t pat;
		int len;
		int i;
		int roll;
		int width;
		logic signed [ID_W-1:0] base;
		logic signed [ID_W-1:0] rising_id;
		buf_op_t op;
		pat = force_window ? IDS_WINDOW : id_pattern_t'($urandom_range(0, 2));
		len = force_window ? 160 : $urandom_range(20, 140);
		base = $urandom;
		width = $urandom_range(70, 200);
		rising_id = base;
		pending_ops.push_back(random_op(KIND_CLEAR));
		for (i = 0; i < len; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 72) begin
				op = random_op(KIND_INSERT);
				case (pat)
					IDS_WIDE: begin
						if ($urandom_range(0, 19) == 0)
							op.id = $urandom_range(0, 1) ? ID_MAX : ID_MIN;
					end
					IDS_WINDOW: begin
						op.id = base + $urandom_range(0, width - 1);
					end
					default: begin
						rising_id = rising_id + $urandom_range(1, 1000);
						op.id = rising_id;
						// now and then a step back lands below the tail or the head
						if ($urandom_range(0, 9) == 0)
							op.id = rising_id - $urandom_range(0, 80000);
					end
				endcase
				pending_ops.push_back(op);
			end else if (roll < 94) begin
				op = random_op(KIND_READ);
				if ($urandom_range(0, 1))
					op.idx = RIDX_W'($urandom_range(0, 7));
				pending_ops.push_back(op);
			end else if (roll < 97 || force_window) begin
				// no stray clears in a forced run, so it fills up
				pending_ops.push_back(random_op(KIND_SPARE));
			end else begin
				pending_ops.push_back(random_op(KIND_CLEAR));
			end
		end
		return len + 1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, exp_val);
		errors++;
	endtask

	// request driver: new word at the falling edge once the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (!req.valid || op_taken)) begin
			if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				next_op = pending_ops.pop_front();
				req.valid <= 1'b1;
				req.kind <= next_op.kind;
				req.entry_id <= next_op.id;
				req.entry_payload <= next_op.payload;
				req.read_index <= next_op.idx;
				req.conversation_in <= next_op.conv;
			end else begin
				req.valid <= 1'b0;
			end
		end
		rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		op_taken <= arst_n && req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			taken_op = '{req.kind, req.entry_id, req.entry_payload, req.read_index,
				req.conversation_in};
			awaited_rsps.push_back(buffer_apply(taken_op));
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (awaited_rsps.size() == 0) begin
				report_mismatch("unexpected result word", 64'(rsp.status), '0);
			end else begin
				want = awaited_rsps.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 64'(rsp.status), 64'(want.status));
				if (rsp.position !== want.position)
					report_mismatch("position", 64'(rsp.position), 64'(want.position));
				if (rsp.evicted !== want.evicted)
					report_mismatch("evicted", 64'(rsp.evicted), 64'(want.evicted));
				if (rsp.entry_count !== want.count)
					report_mismatch("entry_count", 64'(rsp.entry_count), 64'(want.count));
				if (rsp.oldest_id !== want.oldest)
					report_mismatch("oldest_id", 64'(rsp.oldest_id), 64'(want.oldest));
				if (rsp.read_id !== want.rd_id)
					report_mismatch("read_id", 64'(rsp.read_id), 64'(want.rd_id));
				if (rsp.read_payload !== want.rd_pay)
					report_mismatch("read_payload", rsp.read_payload, want.rd_pay);
				if (rsp.conversation !== want.conv)
					report_mismatch("conversation", 64'(rsp.conversation), 64'(want.conv));
			end
		end
	end

	initial begin
		int phase;
		int queued;
		req.valid = 1'b0;
		req.kind = KIND_INSERT;
		req.entry_id = '0;
		req.entry_payload = '0;
		req.read_index = '0;
		req.conversation_in = '0;
		rsp.ready = 1'b0;
		op_taken = 1'b0;
		held_cnt = 0;
		conv_tag = CONV_NONE;
		errors = 0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty reads, the spare kind, id extremes, replace, clears
		queue_op(KIND_READ, 0, 0, 0, 0);
		queue_op(KIND_READ, 0, 0, 63, 0);
		queue_op(KIND_SPARE, 0, 0, 0, 0);
		queue_op(KIND_CLEAR, 0, 0, 0, 255);
		queue_op(KIND_INSERT, 0, 64'h0, 0, 0);
		queue_op(KIND_INSERT, ID_MAX, 64'hffff_ffff_ffff_ffff, 0, 0);
		queue_op(KIND_INSERT, ID_MIN, 64'h5555_5555_5555_5555, 0, 0);
		queue_op(KIND_INSERT, 0, 64'haaaa_aaaa_aaaa_aaaa, 0, 0);
		queue_op(KIND_INSERT, -1, 64'h0123_4567_89ab_cdef, 0, 0);
		queue_op(KIND_READ, 0, 0, 0, 0);
		queue_op(KIND_READ, 0, 0, 1, 0);
		queue_op(KIND_READ, 0, 0, 2, 0);
		queue_op(KIND_READ, 0, 0, 3, 0);
		queue_op(KIND_READ, 0, 0, 4, 0);
		queue_op(KIND_SPARE, 0, 0, 3, 0);
		queue_op(KIND_CLEAR, 0, 0, 0, 0);
		queue_op(KIND_READ, 0, 0, 0, 0);
		queue_op(KIND_INSERT, 32'sh40000000, 64'h8000_0000_0000_0001, 0, 0);
		queue_op(KIND_CLEAR, 0, 0, 0, CONV_NONE);
		queue_op(KIND_READ, 0, 0, 0, 0);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct = 83;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 83;
				end
				default: begin
					send_gap_pct = 30;
					recv_stall_pct = 30;
				end
			endcase
			queued = 0;
			// first run of the test is forced to overflow the buffer
			while (queued < RUN_WORDS / 4)
				queued += queue_run(phase == 0 && queued == 0);
			while (pending_ops.size() != 0 || awaited_rsps.size() != 0 || req.valid)
				@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("sorted_bounded_entry_buffer_test: clean");
		else
			$display("sorted_bounded_entry_buffer_test: errors");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("sorted_bounded_entry_buffer_test: errors");
		$finish;
	end

endmodule
